FILE: sv/spe_pkg.sv
// shared types and constants of the semaphore pool engine
package spe_pkg;

    // operation codes carried on s_tuser
    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_ALLOC   = 2'd2;

    // result error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_RANGE  = 2'd1;
    localparam logic [1:0] ERR_OWNER  = 2'd2;
    localparam logic [1:0] ERR_NOFREE = 2'd3;

    // field widths
    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 6;
    localparam int REQ_W    = 16;
    localparam int COUNT_W  = 7;
    localparam int ERR_W    = 2;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    // entries examined per cycle by the free-entry search
    localparam int SCAN_W = 64;

    // sem_count after reset
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture the input transaction, read the owner store
        logic scan;   // examine one group of entries for a free one
        logic exec;   // decide, update the bank, load the result register
    } spe_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic in_search;  // incoming transaction is an allocate with index 0
        logic scan_hit;   // current group holds a free entry
        logic scan_last;  // current group is the last one
        logic out_free;   // result register can take a new result
    } spe_status_t;

endpackage

FILE: sv/semaphore_pool_engine.sv
// top level of the semaphore pool engine
// A bank of NUM_SEMS spinlock semaphores, each with a lock bit, a 16-bit owner
// id and an in-use mark; entry 0 is reserved. Each input transaction (acquire
// try, release, allocate) returns exactly one result transaction. Items are
// handled one at a time: acquire, release and allocate of an explicit index
// go through capture with owner-store read, then decide and update; an
// allocate with index 0 runs the first-free search between the two, which
// examines 64 entries per cycle and stops at the first group with a hit.
// The decide step waits while the result register still holds an untaken
// result. A finished result waits in an output register while the next
// transaction is taken. Reset frees every lock and clears every owner at once,
// with no clearing pass; sem_count resets to 64. The user must write it only
// while the engine is idle; the block itself does not enforce this.
module semaphore_pool_engine #(
    parameter int NUM_SEMS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [spe_pkg::S_TDATA_W-1:0]  s_tdata,   // sem_index, requester_id, initially_free
    input  logic [spe_pkg::OPCODE_W-1:0]   s_tuser,   // opcode
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [spe_pkg::M_TDATA_W-1:0]  m_tdata,   // granted, result_index, error_code
    // sem_count register
    input  logic                           cfg_wr_en,
    input  logic [spe_pkg::COUNT_W-1:0]    cfg_wr_data
);

    spe_pkg::spe_cmd_t    cmd;
    spe_pkg::spe_status_t status;

    // sequencing
    spe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // bank state and result
    spe_datapath #(
        .NUM_SEMS (NUM_SEMS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

FILE: sv/spe_ctrl.sv
// controller state machine of the semaphore pool engine
module spe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  spe_pkg::spe_status_t status,
    output spe_pkg::spe_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_EXEC   = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = status.in_search ? ST_SEARCH : ST_EXEC;
                end
            end
            ST_SEARCH: begin
                cmd.scan = 1'b1;
                if (status.scan_hit || status.scan_last) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: sv/spe_datapath.sv
// datapath of the semaphore pool engine: bank state, search and result register
module spe_datapath #(
    parameter int NUM_SEMS = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [spe_pkg::S_TDATA_W-1:0]         s_tdata,
    input  logic [spe_pkg::OPCODE_W-1:0]          s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [spe_pkg::M_TDATA_W-1:0]         m_tdata,
    input  logic                                  cfg_wr_en,
    input  logic [spe_pkg::COUNT_W-1:0]           cfg_wr_data,
    input  spe_pkg::spe_cmd_t                     cmd,
    output spe_pkg::spe_status_t                  status
);

    localparam int IDX_W  = $clog2(NUM_SEMS);
    localparam int NCHUNK = (NUM_SEMS + spe_pkg::SCAN_W - 1) / spe_pkg::SCAN_W;
    localparam int CHK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int POS_W  = $clog2(spe_pkg::SCAN_W);
    localparam int CAND_W = NCHUNK * spe_pkg::SCAN_W;

    // input field unpacking
    logic [spe_pkg::INDEX_W-1:0]  in_idx;
    logic [spe_pkg::REQ_W-1:0]    in_req;
    logic                         in_free;
    logic [IDX_W+spe_pkg::INDEX_W-1:0] in_idx_ext;
    logic [IDX_W-1:0]             in_tgt;
    logic                         in_range_err;

    assign in_idx     = s_tdata[5:0];
    assign in_req     = s_tdata[21:6];
    assign in_free    = s_tdata[22];
    assign in_idx_ext = {{IDX_W{1'b0}}, in_idx};
    assign in_tgt     = in_idx_ext[IDX_W-1:0];

    // bank state
    logic [NUM_SEMS-1:0]          lock_free_reg;
    logic [NUM_SEMS-1:0]          owner_empty_reg;
    logic [NUM_SEMS-1:0]          in_use_reg;
    logic [spe_pkg::REQ_W-1:0]    owner_mem [NUM_SEMS];
    logic [spe_pkg::COUNT_W-1:0]  sem_count_reg;

    // captured transaction
    logic [spe_pkg::OPCODE_W-1:0] op_reg;
    logic [spe_pkg::INDEX_W-1:0]  idx_reg;
    logic [spe_pkg::REQ_W-1:0]    req_reg;
    logic                         free_reg;
    logic                         search_reg;
    logic                         range_err_reg;
    logic [IDX_W-1:0]             tgt_reg;
    logic                         hit_reg;
    logic [CHK_W-1:0]             chunk_reg;
    logic [spe_pkg::REQ_W-1:0]    rd_owner_reg;

    // result register
    logic                         m_tvalid_reg;
    logic                         granted_reg;
    logic [spe_pkg::INDEX_W-1:0]  res_idx_reg;
    logic [spe_pkg::ERR_W-1:0]    err_reg;

    // range check of the incoming index
    assign in_range_err = ((in_idx == '0) && (s_tuser != spe_pkg::OP_ALLOC))
                       || ({1'b0, in_idx} >= sem_count_reg)
                       || (32'(in_idx) >= 32'(NUM_SEMS));

    // candidate entries for the search: unowned, above zero, below the count
    logic [CAND_W-1:0] cand;
    genvar gi;
    generate
        for (gi = 0; gi < CAND_W; gi++) begin : g_cand
            if (gi >= 1 && gi < NUM_SEMS) begin : g_live
                assign cand[gi] = owner_empty_reg[gi]
                               && (32'(gi) < 32'(sem_count_reg));
            end else begin : g_dead
                assign cand[gi] = 1'b0;
            end
        end
    endgenerate

    // priority encoder over one group of entries
    logic [spe_pkg::SCAN_W-1:0] scan_bits;
    logic [POS_W-1:0]           scan_pos;
    logic                       scan_hit;
    logic [IDX_W-1:0]           scan_idx;

    assign scan_bits = cand[chunk_reg*spe_pkg::SCAN_W +: spe_pkg::SCAN_W];
    assign scan_hit  = |scan_bits;

    always_comb begin
        scan_pos = '0;
        for (int i = spe_pkg::SCAN_W - 1; i >= 0; i--) begin
            if (scan_bits[i]) begin
                scan_pos = POS_W'(i);
            end
        end
    end

    assign scan_idx = IDX_W'(32'(chunk_reg) * spe_pkg::SCAN_W + 32'(scan_pos));

    // status to the controller
    assign status.in_search = (s_tuser == spe_pkg::OP_ALLOC) && (in_idx == '0);
    assign status.scan_hit  = scan_hit;
    assign status.scan_last = (32'(chunk_reg) == 32'(NCHUNK - 1));
    assign status.out_free  = !m_tvalid_reg || m_tready;

    // decision for the captured transaction
    logic [IDX_W+spe_pkg::INDEX_W-1:0] tgt_ext;
    logic [spe_pkg::REQ_W-1:0]         owner_cur;
    logic                              granted;
    logic [spe_pkg::INDEX_W-1:0]       res_idx;
    logic [spe_pkg::ERR_W-1:0]         err;
    logic                              lf_we;
    logic                              lf_val;
    logic                              own_we;
    logic [spe_pkg::REQ_W-1:0]         own_val;
    logic                              use_we;

    assign tgt_ext   = {{spe_pkg::INDEX_W{1'b0}}, tgt_reg};
    assign owner_cur = owner_empty_reg[tgt_reg] ? '0 : rd_owner_reg;

    always_comb begin
        granted = 1'b0;
        res_idx = idx_reg;
        err     = spe_pkg::ERR_NONE;
        lf_we   = 1'b0;
        lf_val  = 1'b0;
        own_we  = 1'b0;
        own_val = '0;
        use_we  = 1'b0;
        case (op_reg)
            spe_pkg::OP_ACQUIRE: begin
                if (range_err_reg) begin
                    err = spe_pkg::ERR_RANGE;
                end else if (lock_free_reg[tgt_reg]) begin
                    granted = 1'b1;
                    lf_we   = 1'b1;
                    lf_val  = 1'b0;
                    own_we  = 1'b1;
                    own_val = req_reg;
                end
            end
            spe_pkg::OP_RELEASE: begin
                if (range_err_reg) begin
                    err = spe_pkg::ERR_RANGE;
                end else if (owner_cur != req_reg) begin
                    err = spe_pkg::ERR_OWNER;
                end else begin
                    lf_we  = 1'b1;
                    lf_val = 1'b1;
                end
            end
            spe_pkg::OP_ALLOC: begin
                if (search_reg && !hit_reg) begin
                    err     = spe_pkg::ERR_NOFREE;
                    res_idx = '0;
                end else if (!search_reg && range_err_reg) begin
                    err = spe_pkg::ERR_RANGE;
                end else if (search_reg || owner_empty_reg[tgt_reg]) begin
                    // claim: owned and locked unless left free
                    granted = 1'b1;
                    res_idx = tgt_ext[spe_pkg::INDEX_W-1:0];
                    lf_we   = 1'b1;
                    lf_val  = free_reg;
                    own_we  = 1'b1;
                    own_val = free_reg ? '0 : req_reg;
                    use_we  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sem_count_reg <= spe_pkg::COUNT_RESET;
        end else if (cfg_wr_en) begin
            sem_count_reg <= cfg_wr_data;
        end
    end

    // capture of the input transaction and search progress
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg        <= s_tuser;
            idx_reg       <= in_idx;
            req_reg       <= in_req;
            free_reg      <= in_free;
            search_reg    <= status.in_search;
            range_err_reg <= in_range_err;
            tgt_reg       <= in_tgt;
            hit_reg       <= 1'b0;
            chunk_reg     <= '0;
        end else if (cmd.scan) begin
            if (scan_hit) begin
                hit_reg <= 1'b1;
                tgt_reg <= scan_idx;
            end else if (!status.scan_last) begin
                chunk_reg <= CHK_W'(chunk_reg + 1'b1);
            end
        end
    end

    // owner store: written on update, read when a transaction is taken
    always_ff @(posedge aclk) begin
        if (cmd.exec && own_we) begin
            owner_mem[tgt_reg] <= own_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rd_owner_reg <= owner_mem[in_tgt];
        end
    end

    // per-entry flags; an owner-empty entry reads as owner zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lock_free_reg   <= '1;
            owner_empty_reg <= '1;
            in_use_reg      <= '0;
        end else if (cmd.exec) begin
            if (lf_we) begin
                lock_free_reg[tgt_reg] <= lf_val;
            end
            if (own_we) begin
                owner_empty_reg[tgt_reg] <= (own_val == '0);
            end
            if (use_we) begin
                in_use_reg[tgt_reg] <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.exec) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            granted_reg <= granted;
            res_idx_reg <= res_idx;
            err_reg     <= err;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, err_reg, res_idx_reg, granted_reg};

`ifndef ASSERT_OFF
    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten");

    // a granted acquire leaves the lock held
    a_acquire_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && granted && (op_reg == spe_pkg::OP_ACQUIRE))
        |=> !lock_free_reg[$past(tgt_reg)])
        else $error("acquired lock still free");

    // a claimed entry is marked in use
    a_claim_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && granted && (op_reg == spe_pkg::OP_ALLOC))
        |=> in_use_reg[$past(tgt_reg)])
        else $error("claimed entry not marked in use");

    // the search only lands on an unowned entry
    a_search_unowned: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && search_reg && hit_reg) |-> owner_empty_reg[tgt_reg])
        else $error("search found an owned entry");
`endif

endmodule

FILE: verif/spe_checker.sv
// checker of the semaphore pool engine: predicts every result and compares it with the block
`timescale 1ns / 1ps
module spe_checker #(
    parameter int NUM_SEMS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [spe_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [spe_pkg::OPCODE_W-1:0]   s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [spe_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [spe_pkg::COUNT_W-1:0]    cfg_wr_data,
    output int                             fail_count,
    output int                             pending,
    output int                             n_ops,
    output int                             n_granted,
    output int                             n_range,
    output int                             n_owner,
    output int                             n_nofree
);

    typedef struct packed {
        logic                        granted;
        logic [spe_pkg::INDEX_W-1:0] index;
        logic [spe_pkg::ERR_W-1:0]   err;
    } sem_result_t;

    // shadow copy of the semaphore bank
    logic                        lock_free [NUM_SEMS];
    logic [spe_pkg::REQ_W-1:0]   owner     [NUM_SEMS];
    logic                        in_use    [NUM_SEMS];
    logic [spe_pkg::COUNT_W-1:0] sem_count;

    sem_result_t results_due[$];

    // claim an entry, locked and owned unless it is to stay free
    function automatic void claim_entry(int i, logic leave_free,
                                        logic [spe_pkg::REQ_W-1:0] req);
        in_use[i]    = 1'b1;
        lock_free[i] = 1'b1;
        owner[i]     = '0;
        if (!leave_free) begin
            owner[i]     = req;
            lock_free[i] = 1'b0;
        end
    endfunction

    // apply one operation to the shadow bank and return its result
    function automatic sem_result_t apply_sem_op(logic [spe_pkg::OPCODE_W-1:0] op,
                                                 logic [spe_pkg::INDEX_W-1:0] idx,
                                                 logic [spe_pkg::REQ_W-1:0] req,
                                                 logic leave_free);
        int          cnt;
        bit          found;
        sem_result_t r;
        cnt       = (int'(sem_count) > NUM_SEMS) ? NUM_SEMS : int'(sem_count);
        found     = 1'b0;
        r.granted = 1'b0;
        r.index   = idx;
        r.err     = spe_pkg::ERR_NONE;
        case (op)
            spe_pkg::OP_ACQUIRE, spe_pkg::OP_RELEASE: begin
                if (idx == 0 || int'(idx) >= cnt) begin
                    r.err = spe_pkg::ERR_RANGE;
                end else if (op == spe_pkg::OP_ACQUIRE) begin
                    if (lock_free[idx]) begin
                        lock_free[idx] = 1'b0;
                        owner[idx]     = req;
                        r.granted      = 1'b1;
                    end
                end else if (owner[idx] != req) begin
                    r.err = spe_pkg::ERR_OWNER;
                end else begin
                    lock_free[idx] = 1'b1;
                end
            end
            spe_pkg::OP_ALLOC: begin
                if (idx != 0) begin
                    if (int'(idx) >= cnt) begin
                        r.err = spe_pkg::ERR_RANGE;
                    end else if (owner[idx] == '0) begin
                        claim_entry(int'(idx), leave_free, req);
                        r.granted = 1'b1;
                    end
                end else begin
                    // first entry above zero with no owner
                    r.err   = spe_pkg::ERR_NOFREE;
                    r.index = '0;
                    for (int i = 1; i < cnt && !found; i++) begin
                        if (owner[i] == '0) begin
                            claim_entry(i, leave_free, req);
                            found     = 1'b1;
                            r.granted = 1'b1;
                            r.err     = spe_pkg::ERR_NONE;
                            r.index   = i[spe_pkg::INDEX_W-1:0];
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        $display("%0t ns: mismatch in %s: expected %0d, got %0d", $time, what, want, got);
        fail_count++;
    endtask

    // watch both channels and the register port
    always @(posedge aclk) begin : watch
        sem_result_t want;
        sem_result_t got;
        if (!aresetn) begin
            for (int i = 0; i < NUM_SEMS; i++) begin
                lock_free[i] = 1'b1;
                owner[i]     = '0;
                in_use[i]    = 1'b0;
            end
            sem_count = spe_pkg::COUNT_RESET;
            results_due.delete();
            pending <= 0;
        end else begin
            if (cfg_wr_en)
                sem_count = cfg_wr_data;
            // input transaction: predict its result
            if (s_tvalid && s_tready)
                results_due.push_back(apply_sem_op(
                    s_tuser,
                    s_tdata[spe_pkg::INDEX_W-1:0],
                    s_tdata[spe_pkg::INDEX_W +: spe_pkg::REQ_W],
                    s_tdata[spe_pkg::INDEX_W + spe_pkg::REQ_W]));
            // result transaction: compare with the oldest prediction
            if (m_tvalid && m_tready) begin
                got.granted = m_tdata[0];
                got.index   = m_tdata[1 +: spe_pkg::INDEX_W];
                got.err     = m_tdata[1 + spe_pkg::INDEX_W +: spe_pkg::ERR_W];
                n_ops++;
                if (got.granted)
                    n_granted++;
                case (got.err)
                    spe_pkg::ERR_RANGE:  n_range++;
                    spe_pkg::ERR_OWNER:  n_owner++;
                    spe_pkg::ERR_NOFREE: n_nofree++;
                    default: ;
                endcase
                if (results_due.size() == 0) begin
                    $display("%0t ns: result transaction with no operation outstanding", $time);
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    if (got.granted != want.granted)
                        report_mismatch("granted", want.granted, got.granted);
                    if (got.index != want.index)
                        report_mismatch("result_index", want.index, got.index);
                    if (got.err != want.err)
                        report_mismatch("error_code", want.err, got.err);
                end
            end
            pending <= results_due.size();
        end
    end

endmodule

FILE: verif/tb_semaphore_pool_engine.sv
// testbench top of the semaphore pool engine: stimulus, handshake idling and verdict
`timescale 1ns / 1ps
module tb_semaphore_pool_engine;

    localparam int                           NUM_SEMS     = 64;
    localparam logic [spe_pkg::OPCODE_W-1:0] OP_UNUSED    = 2'd3;
    localparam int                           QUIET_LIMIT  = 4000;
    localparam int                           DRAIN_CYCLES = 8;

    logic                             aclk        = 1'b0;
    logic                             aresetn     = 1'b0;
    logic                             s_tvalid    = 1'b0;
    logic                             s_tready;
    logic [spe_pkg::S_TDATA_W-1:0]    s_tdata     = '0;
    logic [spe_pkg::OPCODE_W-1:0]     s_tuser     = '0;
    logic                             m_tvalid;
    logic                             m_tready    = 1'b0;
    logic [spe_pkg::M_TDATA_W-1:0]    m_tdata;
    logic                             cfg_wr_en   = 1'b0;
    logic [spe_pkg::COUNT_W-1:0]      cfg_wr_data = '0;

    int fail_count, pending, n_ops, n_granted, n_range, n_owner, n_nofree;
    int quiet_cycles = 0;
    int cur_count    = 64;
    int n_settings   = 1;
    bit idle_on      = 1'b1;
    logic [spe_pkg::REQ_W-1:0] id_pool [4];

    always #5 aclk = ~aclk;

    semaphore_pool_engine #(.NUM_SEMS(NUM_SEMS)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    spe_checker #(.NUM_SEMS(NUM_SEMS)) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .n_ops       (n_ops),
        .n_granted   (n_granted),
        .n_range     (n_range),
        .n_owner     (n_owner),
        .n_nofree    (n_nofree)
    );

    // result side stalls about one cycle in ten while idling is on
    always @(posedge aclk) begin
        m_tready <= !idle_on || ($urandom_range(99) >= 10);
    end

    // watchdog on cycles with no transaction at all
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one operation; returns at the edge where it is taken
    task automatic send_sem_op(logic [spe_pkg::OPCODE_W-1:0] op,
                               logic [spe_pkg::INDEX_W-1:0] idx,
                               logic [spe_pkg::REQ_W-1:0] req, logic leave_free);
        if (idle_on && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, leave_free, req, idx};
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_count(int value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[spe_pkg::COUNT_W-1:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_count = value;
        n_settings++;
    endtask

    // mostly an index inside the active range, sometimes any index
    function automatic logic [spe_pkg::INDEX_W-1:0] pick_index();
        int eff;
        eff = (cur_count > NUM_SEMS) ? NUM_SEMS : cur_count;
        if (eff >= 2 && $urandom_range(99) < 85)
            return 6'($urandom_range(eff - 1, 1));
        return 6'($urandom_range(63, 0));
    endfunction

    // fresh set of requesters, now and then one with id zero
    task automatic new_id_pool();
        id_pool[0] = 16'($urandom_range(16'hFFFF, 1));
        id_pool[1] = 16'($urandom);
        id_pool[2] = ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0001;
        id_pool[3] = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom);
    endtask

    // lock sessions and allocations with random content, plus noise
    task automatic run_random(int n_items);
        int                          sent;
        int                          kind;
        logic [spe_pkg::INDEX_W-1:0] idx;
        logic [spe_pkg::REQ_W-1:0]   id;
        sent = 0;
        new_id_pool();
        while (sent < n_items) begin
            kind = $urandom_range(99);
            idx  = pick_index();
            id   = id_pool[$urandom_range(3)];
            if (kind < 45) begin
                // acquire, maybe a competing try, then release by the first requester
                send_sem_op(spe_pkg::OP_ACQUIRE, idx, id, 1'($urandom_range(1)));
                if ($urandom_range(3) == 0) begin
                    send_sem_op(spe_pkg::OP_ACQUIRE, idx, id_pool[$urandom_range(3)],
                                1'($urandom_range(1)));
                    sent++;
                end
                send_sem_op(spe_pkg::OP_RELEASE, idx, id, 1'($urandom_range(1)));
                sent += 2;
            end else if (kind < 75) begin
                // allocate by search or by index, then release
                send_sem_op(spe_pkg::OP_ALLOC, ($urandom_range(1) == 1) ? '0 : idx, id,
                            1'($urandom_range(1)));
                send_sem_op(spe_pkg::OP_RELEASE, idx, id, 1'($urandom_range(1)));
                sent += 2;
            end else begin
                send_sem_op(2'($urandom_range(3)), 6'($urandom_range(63)), 16'($urandom),
                            1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: range edges, held lock, owner checks, allocate paths
        send_sem_op(spe_pkg::OP_ACQUIRE, 6'd0,  16'h1111, 1'b0);
        send_sem_op(spe_pkg::OP_ACQUIRE, 6'd63, 16'hFFFF, 1'b0);
        send_sem_op(spe_pkg::OP_ACQUIRE, 6'd63, 16'h0001, 1'b1);
        send_sem_op(spe_pkg::OP_RELEASE, 6'd63, 16'h0001, 1'b0);
        send_sem_op(spe_pkg::OP_RELEASE, 6'd63, 16'hFFFF, 1'b0);
        send_sem_op(spe_pkg::OP_RELEASE, 6'd63, 16'hFFFF, 1'b1);
        send_sem_op(spe_pkg::OP_RELEASE, 6'd0,  16'hFFFF, 1'b0);
        send_sem_op(spe_pkg::OP_ACQUIRE, 6'd5,  16'h0000, 1'b0);
        send_sem_op(spe_pkg::OP_ALLOC,   6'd5,  16'hA5A5, 1'b0);
        send_sem_op(spe_pkg::OP_ALLOC,   6'd5,  16'h0001, 1'b1);
        send_sem_op(spe_pkg::OP_ALLOC,   6'd63, 16'h0002, 1'b0);
        send_sem_op(spe_pkg::OP_ALLOC,   6'd0,  16'h1234, 1'b1);
        send_sem_op(spe_pkg::OP_ALLOC,   6'd0,  16'h5A5A, 1'b0);
        send_sem_op(spe_pkg::OP_ALLOC,   6'd0,  16'h0F0F, 1'b0);
        send_sem_op(OP_UNUSED,           6'd63, 16'hFFFF, 1'b1);
        send_sem_op(spe_pkg::OP_RELEASE, 6'd2,  16'h0F0F, 1'b0);

        // smallest legal count: only entry 1 is served
        write_count(2);
        send_sem_op(spe_pkg::OP_ACQUIRE, 6'd1,  16'h0007, 1'b0);
        send_sem_op(spe_pkg::OP_ALLOC,   6'd2,  16'h0007, 1'b0);
        send_sem_op(spe_pkg::OP_ALLOC,   6'd0,  16'h0007, 1'b0);
        send_sem_op(spe_pkg::OP_RELEASE, 6'd1,  16'h5A5A, 1'b0);

        // counts that serve nothing
        write_count(0);
        send_sem_op(spe_pkg::OP_ACQUIRE, 6'd1,  16'h0003, 1'b0);
        send_sem_op(spe_pkg::OP_ALLOC,   6'd0,  16'h0003, 1'b0);
        write_count(1);
        send_sem_op(spe_pkg::OP_RELEASE, 6'd1,  16'h0003, 1'b0);
        run_random(60);

        // random phases over a spread of counts, one with no idling
        write_count(127);
        run_random(300);
        idle_on = 1'b0;
        write_count(64);
        run_random(400);
        idle_on = 1'b1;
        write_count(33);
        run_random(300);
        write_count(2);
        run_random(150);
        write_count(int'($urandom_range(64, 3)));
        run_random(300);
        write_count(64);
        run_random(250);

        drain_results();
        $display("ran %0d operations over %0d count settings", n_ops, n_settings);
        $display("grants %0d, range errors %0d, owner mismatches %0d, none free %0d",
                 n_granted, n_range, n_owner, n_nofree);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
